[sv/ntc_thermostat_with_hysteresis_defines.svh]
// Assertion macros used by the thermostat controller.
`ifndef NTC_THERMOSTAT_WITH_HYSTERESIS_DEFINES_SVH
`define NTC_THERMOSTAT_WITH_HYSTERESIS_DEFINES_SVH

// Checked on every rising edge outside reset.
`define NTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define NTC_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/ntc_pkg.sv]
// Types, constants and helper functions shared by the thermostat modules.
`default_nettype none

package ntc_pkg;

  localparam int SAMPLE_W      = 10;   // converter sample field width
  localparam int SMP_MAX_W     = 12;   // widest supported converter
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 32;
  localparam int SP_W          = 7;
  localparam int TEMP_W        = 7;
  localparam int BAND_W        = 4;
  localparam int DIGIT_W       = 4;
  localparam int TTENS_W       = 3;
  localparam int VOLT_W        = 9;
  localparam int ENTRY_W       = 14;
  localparam int TABLE_ENTRIES = 80;
  localparam int DIVD_W        = 19;   // dividend and quotient width of the resistance divider
  localparam int DIVS_W        = 10;   // divisor width of the resistance divider

  // Reciprocal constants. q * 3277 >> 15 is q / 10 for any q below 16384, and
  // t * 823133 >> 20 is floor(t * 785 / 1000) for any t below 1024.
  localparam int Q10_MUL_W = 12;
  localparam int Q10_SHIFT = 15;
  localparam int SP_MUL_W  = 20;
  localparam int SP_SHIFT  = 20;

  localparam logic [BAND_W-1:0]    BAND_RESET = 4'd2;
  localparam logic [VOLT_W-1:0]    VOLT_FULL  = 9'd500;
  localparam logic [DIVS_W-1:0]    RES_SCALE  = 10'd1000;
  localparam logic [Q10_MUL_W-1:0] Q10_MUL    = 12'd3277;
  localparam logic [SP_MUL_W-1:0]  SP_MUL     = 20'd823133;
  localparam logic [SP_W-1:0]      SP_MAX     = 7'd127;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     cap_tmp;
    logic     set_sp;
    logic     cap_volt;
    logic     res_sat;
    logic     cap_res;
    logic     idx_clr;
    logic     idx_inc;
    logic     set_temp;
    logic     upd_alarm;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic kind;
    logic div_done;
    logic volt_zero;
    logic hit;
    logic last;
  } dp_status_t;

  localparam logic [ENTRY_W-1:0] RES_TABLE [TABLE_ENTRIES] = '{
    14'd9712, 14'd9166, 14'd8654, 14'd8172, 14'd7722, 14'd7298, 14'd6900, 14'd6526,
    14'd6176, 14'd5534, 14'd5242, 14'd4966, 14'd4708, 14'd4464, 14'd4234, 14'd4016,
    14'd3812, 14'd3620, 14'd3438, 14'd3266, 14'd3104, 14'd2950, 14'd2806, 14'd2668,
    14'd2540, 14'd2418, 14'd2302, 14'd2192, 14'd2088, 14'd1990, 14'd1897, 14'd1809,
    14'd1726, 14'd1646, 14'd1571, 14'd1500, 14'd1432, 14'd1368, 14'd1307, 14'd1249,
    14'd1194, 14'd1142, 14'd1092, 14'd1045, 14'd1000, 14'd957,  14'd916,  14'd877,
    14'd840,  14'd805,  14'd772,  14'd740,  14'd709,  14'd680,  14'd653,  14'd626,
    14'd601,  14'd577,  14'd554,  14'd532,  14'd511,  14'd491,  14'd472,  14'd454,
    14'd436,  14'd420,  14'd404,  14'd388,  14'd374,  14'd360,  14'd346,  14'd334,
    14'd321,  14'd309,  14'd298,  14'd287,  14'd277,  14'd267,  14'd258,  14'd248
  };

  // Entries past the end of the table read as zero.
  function automatic logic [ENTRY_W-1:0] res_entry(input logic [6:0] idx);
    logic [ENTRY_W-1:0] val;
    val = '0;
    if (int'(idx) < TABLE_ENTRIES) begin
      val = RES_TABLE[idx];
    end
    return val;
  endfunction

  // Tens digit of a 7-bit value: (v * 205) >> 11 is exact below 1029.
  function automatic logic [DIGIT_W-1:0] div10(input logic [6:0] v);
    logic [14:0] prod;
    prod = 15'(v) * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [DIGIT_W-1:0] mod10(input logic [6:0] v);
    logic [6:0] tens10;
    logic [6:0] diff;
    tens10 = 7'(div10(v)) * 7'd10;
    diff   = v - tens10;
    return diff[DIGIT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/ntc_thermostat_with_hysteresis.sv]
// Top level of the thermistor thermostat with hysteresis.
`default_nettype none

// Thermostat with hysteresis. Each input item is one converter sample, tagged in
// in_tuser as a potentiometer reading (0) or a thermistor reading (1), and gives
// exactly one output item carrying the current setpoint, temperature, alarm lamp
// and the decimal digits of both. Items are handled one at a time. A potentiometer
// item passes through the states POT_A, POT_B, ALARM and FINISH; a thermistor item
// passes through POT_A, NTC_A and NTC_B, then the 19-step bit-serial divider for
// the resistance and the resistance table walk, which examines one entry per cycle,
// then ALARM and FINISH; a zero thermistor voltage skips the divider. A finished
// item sits in the output register, so the next input item can be taken in the
// cycle after it is loaded, while it waits. The hysteresis band is written through
// the cfg port only while the block is idle; the user must ensure it, not the block.

module ntc_thermostat_with_hysteresis
  import ntc_pkg::*;
#(
  parameter int TABLE_DEPTH = 80,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  // [9:0] sample, [15:10] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [0] kind
  input  wire logic                  in_tuser,
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  // [6:0] setpoint, [13:7] temperature, [14] alarm, [18:15] setpoint_tens,
  // [22:19] setpoint_units, [25:23] temp_tens, [29:26] temp_units, [31:30] zero
  output      logic [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [BAND_W-1:0]     cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  ntc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  ntc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_kind   (in_tuser),
    .in_sample (in_tdata[SAMPLE_W-1:0]),
    .band_we   (cfg_valid && cfg_ready),
    .band_in   (cfg_data),
    .status    (status),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

[sv/ntc_div.sv]
// Restoring divider for the thermistor resistance, one quotient bit per cycle.
`default_nettype none

module ntc_div
  import ntc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output      logic              done,
  output      logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] rem_nxt;
  logic [DIVD_W-1:0] q_r;
  logic [DIVS_W-1:0] dsr_r;
  logic [DIVS_W:0]   part;
  logic [DIVS_W:0]   diff;
  logic              ge;

  // The dividend shifts out of q_r at the top while quotient bits enter at the bottom.
  assign part    = {rem_r, q_r[DIVD_W-1]};
  assign diff    = part - {1'b0, dsr_r};
  assign ge      = part >= {1'b0, dsr_r};
  assign rem_nxt = ge ? diff[DIVS_W-1:0] : part[DIVS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CNT_W'(DIVD_W - 1);
      rem_r <= '0;
      q_r   <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= rem_nxt;
      q_r   <= {q_r[DIVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

[sv/ntc_dp.sv]
// Datapath: sample registers, divider operands, table walk, thermostat state and output item.
`default_nettype none

module ntc_dp
  import ntc_pkg::*;
#(
  parameter int TABLE_DEPTH = 80,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctrl_cmd_t             cmd,
  input  wire logic                  in_kind,
  input  wire logic [SAMPLE_W-1:0]   in_sample,
  input  wire logic                  band_we,
  input  wire logic [BAND_W-1:0]     band_in,
  output      dp_status_t            status,
  output      logic [OUT_DATA_W-1:0] out_data
);

  localparam int WALK_DEPTH = (TABLE_DEPTH < TABLE_ENTRIES) ? TABLE_DEPTH : TABLE_ENTRIES;
  localparam int IDX_W      = (WALK_DEPTH > 1) ? $clog2(WALK_DEPTH) : 1;
  localparam int TQ_W       = SAMPLE_BITS - 3;
  localparam int PROD_W     = SAMPLE_BITS + 10;
  localparam int Q10P_W     = SAMPLE_BITS + Q10_MUL_W;
  localparam int SPP_W      = TQ_W + SP_MUL_W;

  logic                   kind_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [TQ_W-1:0]        tq_r;
  logic [VOLT_W-1:0]      volt_r;
  logic [DIVD_W-1:0]      res_r;
  logic [IDX_W-1:0]       idx_r;
  logic [SP_W-1:0]        sp_r;
  logic [TEMP_W-1:0]      temp_r;
  logic                   alarm_r;
  logic [BAND_W-1:0]      band_r;
  logic [OUT_DATA_W-1:0]  out_data_r;

  logic [SMP_MAX_W-1:0]   smp_wide;
  logic [SAMPLE_BITS:0]   c_val;
  logic [PROD_W-1:0]      volt_prod;
  logic [PROD_W-1:0]      volt_shift;
  logic [Q10P_W-1:0]      q10_prod;
  logic [SPP_W-1:0]       sp_prod;
  logic [SPP_W-1:0]       sp_full;
  logic [DIVD_W-1:0]      res_prod;
  logic [DIVD_W-1:0]      div_dividend;
  logic [DIVS_W-1:0]      div_divisor;
  logic                   div_done;
  logic [DIVD_W-1:0]      div_q;
  logic [ENTRY_W-1:0]     entry;
  logic [SP_W:0]          off_limit;
  logic [DIGIT_W-1:0]     sp_tens;
  logic [DIGIT_W-1:0]     sp_units;
  logic [DIGIT_W-1:0]     t_tens;
  logic [DIGIT_W-1:0]     t_units;

  assign smp_wide   = SMP_MAX_W'(in_sample);
  assign c_val      = {1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, smp_r};
  assign volt_prod  = PROD_W'(c_val) * PROD_W'(VOLT_FULL);
  assign volt_shift = volt_prod >> SAMPLE_BITS;
  // The setpoint scaling is two reciprocal multiplications in separate cycles.
  assign q10_prod   = Q10P_W'(smp_r) * Q10P_W'(Q10_MUL);
  assign sp_prod    = SPP_W'(tq_r) * SPP_W'(SP_MUL);
  assign sp_full    = sp_prod >> SP_SHIFT;
  assign res_prod   = DIVD_W'(VOLT_FULL - volt_r) * DIVD_W'(RES_SCALE);

  assign div_dividend = res_prod;
  assign div_divisor  = DIVS_W'(volt_r);

  ntc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign entry     = res_entry(7'(idx_r));
  assign off_limit = {1'b0, sp_r} + (SP_W + 1)'(band_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      smp_r  <= smp_wide[SAMPLE_BITS-1:0];
    end
    if (cmd.cap_tmp) begin
      tq_r <= q10_prod[Q10_SHIFT +: TQ_W];
    end
    if (cmd.cap_volt) begin
      volt_r <= volt_shift[VOLT_W-1:0];
    end
    // A zero voltage gives an open-ended resistance that matches the first entry.
    if (cmd.res_sat) begin
      res_r <= '1;
    end else if (cmd.cap_res) begin
      res_r <= div_q;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_data_r <= {2'b00, t_units, t_tens[TTENS_W-1:0], sp_units, sp_tens,
                     alarm_r, temp_r, sp_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r    <= '0;
      temp_r  <= '0;
      alarm_r <= 1'b0;
      band_r  <= BAND_RESET;
    end else begin
      if (band_we) begin
        band_r <= band_in;
      end
      if (cmd.set_sp) begin
        sp_r <= (sp_full > SPP_W'(SP_MAX)) ? SP_MAX : sp_full[SP_W-1:0];
      end
      if (cmd.set_temp) begin
        temp_r <= TEMP_W'(idx_r);
      end
      if (cmd.upd_alarm) begin
        if (temp_r <= sp_r) begin
          alarm_r <= 1'b1;
        end else if ({1'b0, temp_r} > off_limit) begin
          alarm_r <= 1'b0;
        end
      end
    end
  end

  assign sp_tens  = div10(sp_r);
  assign sp_units = mod10(sp_r);
  assign t_tens   = div10(temp_r);
  assign t_units  = mod10(temp_r);

  assign status.kind      = kind_r;
  assign status.div_done  = div_done;
  assign status.volt_zero = (volt_r == '0);
  assign status.hit       = (res_r >= DIVD_W'(entry));
  assign status.last      = (idx_r == IDX_W'(WALK_DEPTH - 1));
  assign out_data         = out_data_r;

endmodule

`default_nettype wire

[sv/ntc_ctrl.sv]
// Controller state machine that sequences one item through the datapath.
`default_nettype none

`include "ntc_thermostat_with_hysteresis_defines.svh"

module ntc_ctrl
  import ntc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire dp_status_t status,
  output      ctrl_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_POT_A  = 4'd1;
  localparam logic [3:0] S_POT_B  = 4'd2;
  localparam logic [3:0] S_NTC_A  = 4'd3;
  localparam logic [3:0] S_NTC_B  = 4'd4;
  localparam logic [3:0] S_NTC_BW = 4'd5;
  localparam logic [3:0] S_WALK   = 4'd6;
  localparam logic [3:0] S_ALARM  = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_tvalid_r;
  logic       out_tvalid_nxt;
  logic       slot_free;

  assign in_tready = (state_r == S_IDLE);
  assign slot_free = !out_tvalid_r || out_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_POT_A;
        end
      end
      S_POT_A: begin
        if (status.kind) begin
          state_nxt = S_NTC_A;
        end else begin
          cmd.cap_tmp = 1'b1;
          state_nxt   = S_POT_B;
        end
      end
      S_POT_B: begin
        cmd.set_sp = 1'b1;
        state_nxt  = S_ALARM;
      end
      S_NTC_A: begin
        cmd.cap_volt = 1'b1;
        state_nxt    = S_NTC_B;
      end
      S_NTC_B: begin
        cmd.idx_clr = 1'b1;
        if (status.volt_zero) begin
          cmd.res_sat = 1'b1;
          state_nxt   = S_WALK;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_NTC_BW;
        end
      end
      S_NTC_BW: begin
        if (status.div_done) begin
          cmd.cap_res = 1'b1;
          state_nxt   = S_WALK;
        end
      end
      S_WALK: begin
        // One table entry per cycle; the temperature holds when nothing matches.
        if (status.hit) begin
          cmd.set_temp = 1'b1;
          state_nxt    = S_ALARM;
        end else if (status.last) begin
          state_nxt = S_ALARM;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_ALARM: begin
        cmd.upd_alarm = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

  `NTC_ASSERT(a_load_slot_free, cmd.out_load |-> (!out_tvalid_r || out_tready), "result overwrote a waiting item")
  `NTC_ASSERT(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready, "second item taken before the first was done")
  `NTC_ASSERT(a_no_early_done, cmd.div_start |=> !status.div_done, "divider reported done right after start")
  `NTC_ASSERT_ANY(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_tvalid_r), "controller not idle after reset")

endmodule

`default_nettype wire
